// ----- rtl/small_matrix_add_sub_mult_core_defines.svh -----
// ----------------------------------------------------------------------------
// small matrix add/sub/mult core: assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_ADD_SUB_MULT_CORE_DEFINES_SVH
`define SMALL_MATRIX_ADD_SUB_MULT_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define SMAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define SMAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/smam_pkg.sv -----
// ----------------------------------------------------------------------------
// smam_pkg
// shared constants, types and helpers of the small matrix add/sub/mult core
// ----------------------------------------------------------------------------
`default_nettype none

package smam_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int DIM_W      = 4;
    localparam int FIELD_W    = 3;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [FIELD_W-1:0] FN_STORE_A = 3'd0;
    localparam logic [FIELD_W-1:0] FN_STORE_B = 3'd1;
    localparam logic [FIELD_W-1:0] FN_ADD     = 3'd2;
    localparam logic [FIELD_W-1:0] FN_SUB     = 3'd3;
    localparam logic [FIELD_W-1:0] FN_MUL     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd3;

    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [ADDR_W-1:0]            t_addr;
    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [DIM_W-1:0]             t_dim;

    typedef struct packed {
        t_dim a_rows;
        t_dim a_cols;
        t_dim b_rows;
        t_dim b_cols;
    } t_dims;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        t_addr raddr;
    } t_ram_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_ERR
    } t_state;

    function automatic t_addr elem_addr(t_idx r, t_idx c);
        return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
    endfunction

    function automatic logic dim_ok(t_dim d);
        return (int'(d) >= 1) && (int'(d) <= MAX_DIM);
    endfunction

    function automatic logic idx_in_range(logic [FIELD_W-1:0] v);
        return int'(v) < MAX_DIM;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/smam_ram.sv -----
// ----------------------------------------------------------------------------
// smam_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module smam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/smam_engine.sv -----
// ----------------------------------------------------------------------------
// smam_engine
// request decode, element sequencer, read/arith/accumulate pipeline, output reg
// ----------------------------------------------------------------------------
`default_nettype none

module smam_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [smam_pkg::FIELD_W-1:0]    i_func,
    input  logic [smam_pkg::FIELD_W-1:0]    i_elem_row,
    input  logic [smam_pkg::FIELD_W-1:0]    i_elem_col,
    input  logic signed [smam_pkg::OUT_W-1:0] i_elem_value,
    input  smam_pkg::t_dims                 i_dims,
    output smam_pkg::t_ram_req              o_ram_a,
    output smam_pkg::t_ram_req              o_ram_b,
    input  smam_pkg::t_data                 i_rdata_a,
    input  smam_pkg::t_data                 i_rdata_b,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [smam_pkg::FIELD_W-1:0]    o_out_row,
    output logic [smam_pkg::FIELD_W-1:0]    o_out_col,
    output logic signed [smam_pkg::OUT_W-1:0] o_out_value,
    output logic                            o_size_error,
    output logic                            o_last
);

    import smam_pkg::*;

    t_state r_state, n_state;

    logic w_accept, w_is_run, w_is_mult, w_err;
    logic w_issue, w_out_free, w_load_data, w_load_err;
    logic w_elem_last, w_k_last;
    t_dim w_nc, w_nk;

    t_idx r_i, r_j, r_k, r_last_i, r_last_j, r_last_k;
    logic r_mult, r_sub;

    logic  r_v1, r_first1, r_lastk1;
    logic  r_v2, r_first2, r_lastk2;
    logic  r_acc_done;
    t_data r_prod, r_acc;
    t_data w_mul;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_is_mult = (i_func == FN_MUL);
    assign w_is_run  = (i_func == FN_ADD) || (i_func == FN_SUB) || (i_func == FN_MUL);

    always_comb begin
        if (w_is_mult) begin
            w_err = !dim_ok(i_dims.a_rows) || !dim_ok(i_dims.a_cols)
                 || !dim_ok(i_dims.b_cols) || (i_dims.a_cols != i_dims.b_rows);
            w_nc  = i_dims.b_cols;
            w_nk  = i_dims.a_cols;
        end else begin
            w_err = !dim_ok(i_dims.a_rows) || !dim_ok(i_dims.a_cols)
                 || (i_dims.a_rows != i_dims.b_rows) || (i_dims.a_cols != i_dims.b_cols);
            w_nc  = i_dims.a_cols;
            w_nk  = DIM_W'(1);
        end
    end

    assign w_k_last    = (r_k == r_last_k);
    assign w_elem_last = (r_i == r_last_i) && (r_j == r_last_j);
    assign w_out_free  = !o_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_is_run) begin
                    n_state = w_err ? ST_ERR : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_k_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (r_acc_done && w_out_free) begin
                    n_state = w_elem_last ? ST_IDLE : ST_ISSUE;
                end
            end
            ST_ERR: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready  = 1'b0;
        w_issue     = 1'b0;
        w_load_data = 1'b0;
        w_load_err  = 1'b0;
        case (r_state)
            ST_IDLE:  o_in_ready  = 1'b1;
            ST_ISSUE: w_issue     = 1'b1;
            ST_WAIT:  w_load_data = r_acc_done && w_out_free;
            ST_ERR:   w_load_err  = w_out_free;
            default:  o_in_ready  = 1'b0;
        endcase
    end

    always_comb begin
        o_ram_a.we    = w_accept && (i_func == FN_STORE_A)
                     && idx_in_range(i_elem_row) && idx_in_range(i_elem_col);
        o_ram_a.waddr = elem_addr(IDX_W'(i_elem_row), IDX_W'(i_elem_col));
        o_ram_a.wdata = DATA_WIDTH'(i_elem_value);
        o_ram_a.raddr = elem_addr(r_i, r_mult ? r_k : r_j);

        o_ram_b.we    = w_accept && (i_func == FN_STORE_B)
                     && idx_in_range(i_elem_row) && idx_in_range(i_elem_col);
        o_ram_b.waddr = o_ram_a.waddr;
        o_ram_b.wdata = o_ram_a.wdata;
        o_ram_b.raddr = r_mult ? elem_addr(r_k, r_j) : elem_addr(r_i, r_j);
    end

    assign w_mul = i_rdata_a * i_rdata_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_acc_done <= 1'b0;
            o_out_valid <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_last_i   <= '0;
            r_last_j   <= '0;
            r_last_k   <= '0;
            r_mult     <= 1'b0;
            r_sub      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;

            if (w_load_data) begin
                r_acc_done <= 1'b0;
            end else if (r_v2 && r_lastk2) begin
                r_acc_done <= 1'b1;
            end

            if (w_load_data || w_load_err) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            if (w_accept && w_is_run) begin
                r_i      <= '0;
                r_j      <= '0;
                r_k      <= '0;
                r_mult   <= w_is_mult;
                r_sub    <= (i_func == FN_SUB);
                r_last_i <= IDX_W'(i_dims.a_rows - DIM_W'(1));
                r_last_j <= IDX_W'(w_nc - DIM_W'(1));
                r_last_k <= IDX_W'(w_nk - DIM_W'(1));
            end else if (w_issue) begin
                r_k <= w_k_last ? '0 : r_k + 1'b1;
            end else if (w_load_data) begin
                if (r_j == r_last_j) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_first1 <= (r_k == '0);
        r_lastk1 <= w_k_last;
        r_first2 <= r_first1;
        r_lastk2 <= r_lastk1;

        if (r_mult) begin
            r_prod <= w_mul;
        end else if (r_sub) begin
            r_prod <= i_rdata_a - i_rdata_b;
        end else begin
            r_prod <= i_rdata_a + i_rdata_b;
        end

        if (r_v2) begin
            r_acc <= r_first2 ? r_prod : r_acc + r_prod;
        end

        if (w_load_data) begin
            o_out_row    <= FIELD_W'(r_i);
            o_out_col    <= FIELD_W'(r_j);
            o_out_value  <= OUT_W'(r_acc);
            o_size_error <= 1'b0;
            o_last       <= w_elem_last;
        end else if (w_load_err) begin
            o_out_row    <= '0;
            o_out_col    <= '0;
            o_out_value  <= '0;
            o_size_error <= 1'b1;
            o_last       <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/small_matrix_add_sub_mult_core.sv -----
// store requests: one per cycle while no run is busy, no result
// add/sub: one element in flight through the ram read, arith and accumulate registers
// multiply: a_cols products accumulated per result, one element in flight through the
//   ram read, multiply and accumulate registers
// size error: one result, through the error state to the output register
// reset: synchronous active low, dims back to 1, matrix rams keep contents
// ----------------------------------------------------------------------------
// small_matrix_add_sub_mult_core
// two ram-backed signed matrices, streaming sum, difference or product
// ----------------------------------------------------------------------------
`default_nettype none

module small_matrix_add_sub_mult_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [smam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [smam_pkg::DIM_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [smam_pkg::FIELD_W-1:0]      i_func,
    input  logic [smam_pkg::FIELD_W-1:0]      i_elem_row,
    input  logic [smam_pkg::FIELD_W-1:0]      i_elem_col,
    input  logic signed [smam_pkg::OUT_W-1:0] i_elem_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [smam_pkg::FIELD_W-1:0]      o_out_row,
    output logic [smam_pkg::FIELD_W-1:0]      o_out_col,
    output logic signed [smam_pkg::OUT_W-1:0] o_out_value,
    output logic                              o_size_error,
    output logic                              o_last
);

    import smam_pkg::*;

    t_dims    r_dims;
    t_ram_req w_ram_a, w_ram_b;
    t_data    w_rdata_a, w_rdata_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.a_rows <= DIM_W'(1);
            r_dims.a_cols <= DIM_W'(1);
            r_dims.b_rows <= DIM_W'(1);
            r_dims.b_cols <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_A_ROWS: r_dims.a_rows <= i_cfg_data;
                CFG_A_COLS: r_dims.a_cols <= i_cfg_data;
                CFG_B_ROWS: r_dims.b_rows <= i_cfg_data;
                CFG_B_COLS: r_dims.b_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    smam_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_ram_a.we),
        .i_waddr (w_ram_a.waddr),
        .i_wdata (w_ram_a.wdata),
        .i_raddr (w_ram_a.raddr),
        .o_rdata (w_rdata_a)
    );

    smam_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_ram_b.we),
        .i_waddr (w_ram_b.waddr),
        .i_wdata (w_ram_b.wdata),
        .i_raddr (w_ram_b.raddr),
        .o_rdata (w_rdata_b)
    );

    smam_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_elem_row   (i_elem_row),
        .i_elem_col   (i_elem_col),
        .i_elem_value (i_elem_value),
        .i_dims       (r_dims),
        .o_ram_a      (w_ram_a),
        .o_ram_b      (w_ram_b),
        .i_rdata_a    (w_rdata_a),
        .i_rdata_b    (w_rdata_b),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_value  (o_out_value),
        .o_size_error (o_size_error),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/smam_checker.sv -----
// ----------------------------------------------------------------------------
// smam_checker
// port-level checks of the small matrix add/sub/mult core, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none
`include "small_matrix_add_sub_mult_core_defines.svh"

module smam_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic [smam_pkg::FIELD_W-1:0]      i_func,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [smam_pkg::FIELD_W-1:0]      o_out_row,
    input logic [smam_pkg::FIELD_W-1:0]      o_out_col,
    input logic signed [smam_pkg::OUT_W-1:0] o_out_value,
    input logic                              o_size_error,
    input logic                              o_last
);

    import smam_pkg::*;

    logic w_run_req;

    assign w_run_req = i_in_valid && o_in_ready
                    && ((i_func == FN_ADD) || (i_func == FN_SUB) || (i_func == FN_MUL));

    `SMAM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_value) && $stable(o_last), "result dropped or changed while stalled")
    `SMAM_ASSERT_NOW(a_err_form, o_out_valid && o_size_error, o_last && (o_out_row == '0) && (o_out_col == '0) && (o_out_value == '0), "malformed size error result")
    `SMAM_ASSERT_NOW(a_run_busy, o_out_valid && !o_last, !o_in_ready, "request taken in the middle of a run")
    `SMAM_ASSERT_NEXT(a_run_start, w_run_req, !o_in_ready, "ready held after a run request")

endmodule

bind small_matrix_add_sub_mult_core smam_checker u_smam_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: small matrix add/sub/mult core
// loads matrices a and b through store requests, runs sums, differences and
// products under varied dimension settings and compares every streamed result
// element with a predictor that mirrors the stores, the dimensions and the
// wrapping arithmetic; idling on both channels varies by phase
// ----------------------------------------------------------------------------
module tb;
    import smam_pkg::*;

    localparam logic [FIELD_W-1:0]   FN_FIRST_UNUSED = FN_MUL + 1'b1;
    localparam logic [FIELD_W-1:0]   FN_LAST_CODE    = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_B_COLS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX  = '1;
    localparam int STALL_LIMIT = 5000;
    localparam int IDLE_HOLD   = 12;
    localparam int END_HOLD    = 40;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [OUT_W-1:0]   value;
        logic               err;
        logic               last;
    } t_result_elem;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [FIELD_W-1:0] in_func = '0;
    logic [FIELD_W-1:0] in_row = '0;
    logic [FIELD_W-1:0] in_col = '0;
    logic signed [OUT_W-1:0] in_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [FIELD_W-1:0] out_row;
    logic [FIELD_W-1:0] out_col;
    logic signed [OUT_W-1:0] out_value;
    logic               out_size_error;
    logic               out_last;

    t_data        mat_a [DEPTH];
    t_data        mat_b [DEPTH];
    bit           a_written [DEPTH];
    bit           b_written [DEPTH];
    t_dim         dim_a_rows = 1, dim_a_cols = 1, dim_b_rows = 1, dim_b_cols = 1;
    t_result_elem pending_results [$];
    int           n_fail = 0;
    int           n_sent = 0;
    int           idle_cycles = 0;
    int           send_idle_pct = 19;
    int           recv_idle_pct = 56;

    small_matrix_add_sub_mult_core uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_func       (in_func),
        .i_elem_row   (in_row),
        .i_elem_col   (in_col),
        .i_elem_value (in_value),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_row    (out_row),
        .o_out_col    (out_col),
        .o_out_value  (out_value),
        .o_size_error (out_size_error),
        .o_last       (out_last)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int slot(int r, int c);
        return r * MAX_DIM + c;
    endfunction

    function automatic bit dim_in_range(t_dim d);
        return (d >= 1) && (d <= MAX_DIM);
    endfunction

    task automatic report_mismatch(input string what);
        n_fail++;
        if (n_fail <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    task automatic push_error_result();
        t_result_elem e;
        e.row = '0;
        e.col = '0;
        e.value = '0;
        e.err = 1'b1;
        e.last = 1'b1;
        pending_results.push_back(e);
    endtask

    // matrix stores and the result stream of one accepted request
    task automatic predict_matrix_op(input logic [FIELD_W-1:0] func,
                                     input logic [FIELD_W-1:0] row,
                                     input logic [FIELD_W-1:0] col,
                                     input t_data value);
        t_result_elem e;
        logic [OUT_W-1:0] acc;
        bit fits;
        int nr, nc;
        case (func)
            FN_STORE_A: begin
                mat_a[slot(row, col)] = value;
                a_written[slot(row, col)] = 1'b1;
            end
            FN_STORE_B: begin
                mat_b[slot(row, col)] = value;
                b_written[slot(row, col)] = 1'b1;
            end
            FN_ADD, FN_SUB, FN_MUL: begin
                if (func == FN_MUL) begin
                    fits = dim_in_range(dim_a_rows) && dim_in_range(dim_a_cols)
                        && dim_in_range(dim_b_cols) && dim_a_cols == dim_b_rows;
                    nc = dim_b_cols;
                end else begin
                    fits = dim_in_range(dim_a_rows) && dim_in_range(dim_a_cols)
                        && dim_a_rows == dim_b_rows && dim_a_cols == dim_b_cols;
                    nc = dim_a_cols;
                end
                nr = dim_a_rows;
                if (!fits) begin
                    push_error_result();
                end else begin
                    for (int i = 0; i < nr; i++) begin
                        for (int j = 0; j < nc; j++) begin
                            if (func == FN_MUL) begin
                                acc = '0;
                                for (int k = 0; k < dim_a_cols; k++) begin
                                    acc = acc + mat_a[slot(i, k)] * mat_b[slot(k, j)];
                                end
                            end else if (func == FN_ADD) begin
                                acc = mat_a[slot(i, j)] + mat_b[slot(i, j)];
                            end else begin
                                acc = mat_a[slot(i, j)] - mat_b[slot(i, j)];
                            end
                            e.row = FIELD_W'(i);
                            e.col = FIELD_W'(j);
                            e.value = acc;
                            e.err = 1'b0;
                            e.last = (i == nr - 1) && (j == nc - 1);
                            pending_results.push_back(e);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [FIELD_W-1:0] func,
                                input logic [FIELD_W-1:0] row,
                                input logic [FIELD_W-1:0] col,
                                input t_data value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_func <= func;
        in_row <= row;
        in_col <= col;
        in_value <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_matrix_op(func, row, col, value);
        n_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input t_dim value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            CFG_A_ROWS: dim_a_rows = value;
            CFG_A_COLS: dim_a_cols = value;
            CFG_B_ROWS: dim_b_rows = value;
            CFG_B_COLS: dim_b_cols = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_dims(input t_dim ar, input t_dim ac, input t_dim br, input t_dim bc);
        cfg_write(CFG_A_ROWS, ar);
        cfg_write(CFG_A_COLS, ac);
        cfg_write(CFG_B_ROWS, br);
        cfg_write(CFG_B_COLS, bc);
    endtask

    task automatic wait_for_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (IDLE_HOLD) @(posedge clk);
    endtask

    function automatic t_data pick_value();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '1;
            3: return '0;
            4: return t_data'($urandom_range(15)) - 8;
            default: return t_data'($urandom);
        endcase
    endfunction

    function automatic t_dim pick_dim();
        if ($urandom_range(15) < 2) return t_dim'(MAX_DIM);
        return t_dim'($urandom_range(4, 1));
    endfunction

    task automatic send_unused_code();
        send_request($urandom_range(FN_LAST_CODE, FN_FIRST_UNUSED), $urandom, $urandom,
                     pick_value());
    endtask

    task automatic send_overwrites();
        int n;
        n = $urandom_range(6, 1);
        repeat (n) begin
            send_request($urandom_range(1) ? FN_STORE_B : FN_STORE_A, $urandom, $urandom,
                         pick_value());
        end
    endtask

    // every entry that a run under these dimensions may read gets written
    task automatic fill_missing(input t_dim ar, input t_dim ac, input t_dim br, input t_dim bc);
        int ra, ca, rb, cb;
        ra = (ar > MAX_DIM) ? MAX_DIM : ar;
        ca = (ac > MAX_DIM) ? MAX_DIM : ac;
        rb = (br > MAX_DIM) ? MAX_DIM : br;
        cb = (bc > MAX_DIM) ? MAX_DIM : bc;
        for (int r = 0; r < ra; r++) begin
            for (int c = 0; c < ca; c++) begin
                if (!a_written[slot(r, c)]) begin
                    send_request(FN_STORE_A, FIELD_W'(r), FIELD_W'(c), pick_value());
                end
            end
        end
        for (int r = 0; r < rb; r++) begin
            for (int c = 0; c < cb; c++) begin
                if (!b_written[slot(r, c)]) begin
                    send_request(FN_STORE_B, FIELD_W'(r), FIELD_W'(c), pick_value());
                end
            end
        end
    endtask

    task automatic test_wrap_one_by_one();
        send_request(FN_STORE_A, 0, 0, 32'h7fff_ffff);
        send_request(FN_STORE_B, 0, 0, 32'h0000_0001);
        send_request(FN_ADD, $urandom, $urandom, $urandom);
        send_request(FN_SUB, $urandom, $urandom, $urandom);
        send_request(FN_MUL, $urandom, $urandom, $urandom);
        send_request(FN_STORE_A, 0, 0, 32'h8000_0000);
        send_request(FN_STORE_B, 0, 0, 32'h7fff_ffff);
        send_request(FN_ADD, $urandom, $urandom, $urandom);
        send_request(FN_SUB, $urandom, $urandom, $urandom);
        send_request(FN_MUL, $urandom, $urandom, $urandom);
    endtask

    task automatic test_unused_codes();
        for (int f = FN_FIRST_UNUSED; f <= FN_LAST_CODE; f++) begin
            send_request(FIELD_W'(f), $urandom, $urandom, $urandom);
        end
        send_request(FN_STORE_A, 7, 7, '1);
        send_request(FN_STORE_B, 7, 7, '0);
    endtask

    task automatic test_size_errors();
        wait_for_idle();
        cfg_write(CFG_A_COLS, 0);
        send_request(FN_MUL, 0, 0, 0);
        send_request(FN_ADD, 0, 0, 0);
        wait_for_idle();
        cfg_write(CFG_A_COLS, 1);
        cfg_write(CFG_B_COLS, '1);
        send_request(FN_MUL, 0, 0, 0);
        send_request(FN_ADD, 0, 0, 0);
        wait_for_idle();
        set_dims('1, '1, '1, '1);
        send_request(FN_ADD, 0, 0, 0);
        send_request(FN_SUB, 0, 0, 0);
        wait_for_idle();
        set_dims(1, 1, 1, 1);
        for (int i = CFG_FIRST_SPARE; i <= CFG_LAST_INDEX; i++) begin
            cfg_write(CFG_IDX_W'(i), $urandom);
        end
        send_request(FN_ADD, 0, 0, 0);
    endtask

    // one dimension setting: fill what it reads, then a few runs with stores
    // and unused codes or a wait for idle between them
    task automatic run_random_batch(input bit force_max);
        t_dim ar, ac, br, bc;
        int kind, n_runs;
        wait_for_idle();
        kind = $urandom_range(99);
        if (force_max) begin
            ar = MAX_DIM;
            ac = MAX_DIM;
            br = MAX_DIM;
            bc = MAX_DIM;
        end else if (kind < 15) begin
            ar = $urandom;
            ac = $urandom;
            br = $urandom;
            bc = $urandom;
        end else begin
            ar = pick_dim();
            ac = pick_dim();
            if (kind < 55) begin
                br = ar;
                bc = ac;
            end else begin
                br = ac;
                bc = pick_dim();
            end
        end
        set_dims(ar, ac, br, bc);
        if ($urandom_range(3) == 0) begin
            cfg_write($urandom_range(CFG_LAST_INDEX, CFG_FIRST_SPARE), $urandom);
        end
        fill_missing(ar, ac, br, bc);
        send_overwrites();
        n_runs = $urandom_range(3, 1);
        repeat (n_runs) begin
            send_request(force_max ? FN_MUL : $urandom_range(FN_MUL, FN_ADD),
                         $urandom, $urandom, pick_value());
            case ($urandom_range(3))
                0: send_unused_code();
                1: send_overwrites();
                2: wait_for_idle();
                default: ;
            endcase
        end
    endtask

    always @(posedge clk) begin : check_results
        t_result_elem want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                          out_row, out_col, out_value));
            end else begin
                want = pending_results.pop_front();
                if (out_row !== want.row)
                    report_mismatch($sformatf("row %0d, want %0d", out_row, want.row));
                if (out_col !== want.col)
                    report_mismatch($sformatf("col %0d, want %0d", out_col, want.col));
                if (out_value !== want.value)
                    report_mismatch($sformatf("value %h, want %h at (%0d,%0d)",
                                              out_value, want.value, want.row, want.col));
                if (out_size_error !== want.err)
                    report_mismatch($sformatf("size error %b, want %b",
                                              out_size_error, want.err));
                if (out_last !== want.last)
                    report_mismatch($sformatf("last %b, want %b at (%0d,%0d)",
                                              out_last, want.last, want.row, want.col));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_wrap_one_by_one();
        test_unused_codes();
        test_size_errors();

        while (n_sent < 180) run_random_batch(1'b0);
        wait_for_idle();
        send_idle_pct = 56;
        recv_idle_pct = 19;
        while (n_sent < 330) run_random_batch(1'b0);
        wait_for_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_batch(1'b1);
        while (n_sent < 450) run_random_batch(1'b0);

        wait_for_idle();
        repeat (END_HOLD) @(posedge clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never came", pending_results.size()));
        end
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
